### hw/rtl/at_response_line_decoder_top_assert.svh
// assertion macros for the at response line decoder
`ifndef AT_RESPONSE_LINE_DECODER_TOP_ASSERT_SVH
`define AT_RESPONSE_LINE_DECODER_TOP_ASSERT_SVH

// plain property, checked out of reset
`define ATRLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ATRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/atrld_pkg.sv
package atrld_pkg;

  // sizes and limits
  localparam int LineHeadDepth = 8;
  localparam int LengthMax     = 15;
  localparam int CaptureMax    = 5;
  localparam int ValueW        = 14;
  localparam logic [ValueW-1:0] ValueMax = 14'd9999;

  // characters of interest
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // line heads that are recognized
  localparam logic [0:1][7:0] OkText     = "OK";
  localparam logic [0:4][7:0] ErrorText  = "ERROR";
  localparam logic [0:7][7:0] NsonmiText = "+NSONMI:";

  // result status codes
  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusError   = 2'd1,
    StatusTimeout = 2'd2,
    StatusNotify  = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    status_e             status;
    logic [ValueW-1:0]   socket_number;
    logic [ValueW-1:0]   byte_count;
  } result_t;

  // decimal accumulate with saturation
  function automatic logic [ValueW-1:0] add_digit(logic [ValueW-1:0] acc, logic [3:0] d);
    logic [ValueW+2:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(ValueW-1){1'b0}}, d};
    return (v > {3'b000, ValueMax}) ? ValueMax : v[ValueW-1:0];
  endfunction

endpackage

### hw/rtl/at_response_line_decoder_top.sv
// channel   | dir | tdata                         | tuser      | tlast
// s_axis    | in  | byte_value[7:0]               | kind       | -
// m_axis    | out | socket_number[13:0],          | status     | -
//           |     | byte_count[27:14], zero pad   |            |
// cfg       | in  | notify_enable (wr_en/wr_data) | -          | -
//
// one byte or timeout is taken per cycle while ready is high; all of its work
// is a single pass of logic from the request into the line state and the
// result register. results wait in an output register backed by a one-entry
// skid stage, so requests keep flowing while one result is stalled; ready drops
// only when both hold a result. asynchronous active-low reset brings the line
// state to idle and notify_enable to 1; there is no clearing pass.
module at_response_line_decoder_top #(
  parameter int LINE_HEAD_DEPTH = atrld_pkg::LineHeadDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,  // notify_enable
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] socket_number, [27:14] byte_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int VW = atrld_pkg::ValueW;

  // line and capture state
  logic [7:0]    head_q [LINE_HEAD_DEPTH];
  logic [7:0]    head_d [LINE_HEAD_DEPTH];
  logic [3:0]    len_q, len_d;
  logic          cr_q, cr_d;
  logic          plus_q, plus_d;
  logic          pend_q, pend_d;
  logic [2:0]    cap_q, cap_d;
  logic [VW-1:0] sock_q, sock_d;
  logic [VW-1:0] cnt_q, cnt_d;
  logic          comma_q, comma_d;
  logic          halt_q, halt_d;
  logic          enable_q;

  // output register and skid stage
  logic                out_valid_q, out_valid_d;
  atrld_pkg::result_t  out_q, out_d;
  logic                skid_valid_q, skid_valid_d;
  atrld_pkg::result_t  skid_q, skid_d;

  logic               accept, pop, produced;
  atrld_pkg::result_t res;
  logic [7:0]         b;
  logic               is_blank, is_digit, head_ok, head_err, head_ns;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  assign is_blank = (b == atrld_pkg::ChSpace) ||
                    ((b >= atrld_pkg::ChTab) && (b <= atrld_pkg::ChCr));
  assign is_digit = (b >= atrld_pkg::ChZero) && (b <= atrld_pkg::ChNine);

  // per-request line decode
  always_comb begin
    head_d   = head_q;
    len_d    = len_q;
    cr_d     = cr_q;
    plus_d   = plus_q;
    pend_d   = pend_q;
    cap_d    = cap_q;
    sock_d   = sock_q;
    cnt_d    = cnt_q;
    comma_d  = comma_q;
    halt_d   = halt_q;
    produced = 1'b0;
    res      = '{status: atrld_pkg::StatusOk, socket_number: '0, byte_count: '0};
    head_ok  = 1'b0;
    head_err = 1'b0;
    head_ns  = 1'b0;

    if (accept) begin
      if (s_axis_tuser) begin
        // read timeout ends the command
        res.status = atrld_pkg::StatusTimeout;
        produced   = 1'b1;
        for (int i = 0; i < LINE_HEAD_DEPTH; i++) head_d[i] = '0;
        len_d   = '0;
        cr_d    = 1'b0;
        plus_d  = 1'b0;
        pend_d  = 1'b0;
        cap_d   = '0;
        sock_d  = '0;
        cnt_d   = '0;
        comma_d = 1'b0;
        halt_d  = 1'b0;
      end else begin
        if (b == atrld_pkg::ChPlus && len_q == 4'd0) plus_d = 1'b1;

        // store into line head and count length
        if (b != atrld_pkg::ChCr && b != atrld_pkg::ChLf) begin
          if (len_q != 4'(atrld_pkg::LengthMax)) begin
            len_d = len_q + 4'd1;
            for (int i = 0; i < LINE_HEAD_DEPTH; i++) begin
              if (len_q == 4'(i)) head_d[i] = b;
            end
          end
        end

        // cr-lf closes the line and reports a pending notification if enabled
        if (cr_q && b == atrld_pkg::ChLf) begin
          for (int i = 0; i < LINE_HEAD_DEPTH; i++) head_d[i] = '0;
          len_d  = '0;
          plus_d = 1'b0;
          if (pend_q) begin
            if (enable_q) begin
              res.status        = atrld_pkg::StatusNotify;
              res.socket_number = sock_q;
              res.byte_count    = comma_q ? cnt_q : '0;
              produced          = 1'b1;
            end
            pend_d  = 1'b0;
            cap_d   = '0;
            sock_d  = '0;
            cnt_d   = '0;
            comma_d = 1'b0;
            halt_d  = 1'b0;
          end
        end

        // capture of notification parameters
        if (plus_d && pend_d && !is_blank && cap_d != 3'(atrld_pkg::CaptureMax)) begin
          cap_d = cap_d + 3'd1;
          if (b == atrld_pkg::ChComma) begin
            comma_d = 1'b1;
            cnt_d   = '0;
            halt_d  = 1'b0;
          end else if (!halt_d) begin
            if (is_digit) begin
              if (comma_d) cnt_d = atrld_pkg::add_digit(cnt_d, b[3:0]);
              else         sock_d = atrld_pkg::add_digit(sock_d, b[3:0]);
            end else begin
              halt_d = 1'b1;
            end
          end
        end

        // line head matches
        head_ok  = (len_d >= 4'd2) && head_d[0] == atrld_pkg::OkText[0] &&
                   head_d[1] == atrld_pkg::OkText[1];
        head_err = (len_d >= 4'd5);
        for (int i = 0; i < 5; i++) begin
          if (head_d[i] != atrld_pkg::ErrorText[i]) head_err = 1'b0;
        end
        head_ns = plus_d && (len_d == 4'd8);
        for (int i = 0; i < 8; i++) begin
          if (head_d[i] != atrld_pkg::NsonmiText[i]) head_ns = 1'b0;
        end

        if (head_ok || head_err) begin
          // final response ends the command
          res.status        = head_ok ? atrld_pkg::StatusOk : atrld_pkg::StatusError;
          res.socket_number = '0;
          res.byte_count    = '0;
          produced          = 1'b1;
          for (int i = 0; i < LINE_HEAD_DEPTH; i++) head_d[i] = '0;
          len_d   = '0;
          cr_d    = 1'b0;
          plus_d  = 1'b0;
          pend_d  = 1'b0;
          cap_d   = '0;
          sock_d  = '0;
          cnt_d   = '0;
          comma_d = 1'b0;
          halt_d  = 1'b0;
        end else begin
          if (head_ns) pend_d = 1'b1;
          cr_d = (b == atrld_pkg::ChCr);
        end
      end
    end
  end

  // output register and skid stage steering
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = produced;
        out_d       = res;
      end
    end else if (produced) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_HEAD_DEPTH; i++) head_q[i] <= '0;
      len_q        <= '0;
      cr_q         <= 1'b0;
      plus_q       <= 1'b0;
      pend_q       <= 1'b0;
      cap_q        <= '0;
      sock_q       <= '0;
      cnt_q        <= '0;
      comma_q      <= 1'b0;
      halt_q       <= 1'b0;
      enable_q     <= 1'b1;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_q       <= head_d;
      len_q        <= len_d;
      cr_q         <= cr_d;
      plus_q       <= plus_d;
      pend_q       <= pend_d;
      cap_q        <= cap_d;
      sock_q       <= sock_d;
      cnt_q        <= cnt_d;
      comma_q      <= comma_d;
      halt_q       <= halt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (cfg_wr_en_i) enable_q <= cfg_wr_data_i;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {4'b0000, out_q.byte_count, out_q.socket_number};

  // checks
  `include "at_response_line_decoder_top_assert.svh"

  `ATRLD_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid holds a result ahead of output register")
  `ATRLD_ASSERT_NEXT(a_timeout_idles, accept && s_axis_tuser, len_q == 4'd0 && !pend_q && !plus_q && cap_q == 3'd0, "timeout did not return line state to idle")
  `ATRLD_ASSERT(a_value_range, !out_valid_q || (out_q.socket_number <= atrld_pkg::ValueMax && out_q.byte_count <= atrld_pkg::ValueMax), "result value above decimal limit")

endmodule

### verif/at_response_line_decoder_top_test.sv
module at_response_line_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import atrld_pkg::*;

  // request kinds carried on s_axis_tuser
  localparam logic KindByte    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 12;
  localparam int StuckLimit    = 3000;
  localparam int PhaseItems    = 250;
  localparam int NumPhases     = 6;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } modem_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic        cfg_wr_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
  logic        s_axis_tuser = 1'b0;    // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [13:0] socket_number, [27:14] byte_count
  logic [1:0]  m_axis_tuser;           // [1:0] status

  at_response_line_decoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // requests waiting for the driver and status reports still owed by the block
  modem_req_t modem_reqs[$];
  result_t    due_reports[$];

  int  items_queued = 0;
  int  mismatches = 0;
  int  stuck_cycles = 0;
  int  send_wait = 0;
  int  sink_wait = 0;
  int  hold_left = 0;
  int  holdoff_req = 0;
  int  holdoff_seen = 0;
  bit  sender_burst = 1'b0;
  bit  sink_burst = 1'b0;

  // mirror of the decoder line state
  bit                notify_en = 1'b1;
  bit [7:0]          head_bytes [LineHeadDepth];
  int unsigned       line_len = 0;
  bit                cr_seen = 1'b0;
  bit                plus_ln = 1'b0;
  bit                notif_pend = 1'b0;
  int unsigned       cap_cnt = 0;
  logic [ValueW-1:0] sock_acc = '0;
  logic [ValueW-1:0] cnt_acc = '0;
  bit                comma_seen = 1'b0;
  bit                digits_stop = 1'b0;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit busy();
    return modem_reqs.size() != 0 || s_axis_tvalid || due_reports.size() != 0;
  endfunction

  // line and capture clearing, as the block does at line end and command end
  task automatic clear_line();
    foreach (head_bytes[i]) head_bytes[i] = 8'h00;
    line_len = 0;
    plus_ln = 1'b0;
  endtask

  task automatic clear_capture();
    cap_cnt = 0;
    sock_acc = '0;
    cnt_acc = '0;
    comma_seen = 1'b0;
    digits_stop = 1'b0;
  endtask

  task automatic go_idle();
    clear_line();
    clear_capture();
    cr_seen = 1'b0;
    notif_pend = 1'b0;
  endtask

  function automatic logic [ValueW-1:0] add_decimal(logic [ValueW-1:0] acc, logic [7:0] ch);
    int unsigned v;
    v = acc * 10 + (ch - ChZero);
    return (v > ValueMax) ? ValueMax : v[ValueW-1:0];
  endfunction

  // notification payload: socket before the first comma, count after the last
  task automatic capture_char(logic [7:0] b);
    if (cap_cnt >= CaptureMax) return;
    cap_cnt++;
    if (b == ChComma) begin
      comma_seen = 1'b1;
      cnt_acc = '0;
      digits_stop = 1'b0;
      return;
    end
    if (digits_stop) return;
    if (b >= ChZero && b <= ChNine) begin
      if (comma_seen) cnt_acc = add_decimal(cnt_acc, b);
      else sock_acc = add_decimal(sock_acc, b);
    end else begin
      digits_stop = 1'b1;
    end
  endtask

  // predicted effect of one accepted request
  task automatic decode_byte(logic kind, logic [7:0] b);
    bit ok_hit, err_hit, nsonmi_hit, blank;
    if (kind == KindTimeout) begin
      due_reports.push_back('{StatusTimeout, '0, '0});
      go_idle();
      return;
    end
    if (b == ChPlus && line_len == 0) plus_ln = 1'b1;
    if (b != ChCr && b != ChLf) begin
      if (line_len < LineHeadDepth && line_len < LengthMax) head_bytes[line_len] = b;
      if (line_len < LengthMax) line_len++;
    end
    // cr-lf closes the line and flushes a pending notification
    if (cr_seen && b == ChLf) begin
      clear_line();
      if (notif_pend) begin
        if (notify_en)
          due_reports.push_back('{StatusNotify, sock_acc, comma_seen ? cnt_acc : '0});
        notif_pend = 1'b0;
        clear_capture();
      end
    end
    blank = (b == ChSpace) || (b >= ChTab && b <= ChCr);
    if (plus_ln && notif_pend && !blank) capture_char(b);
    // command end on a recognized line head
    ok_hit = line_len >= 2;
    for (int i = 0; i < 2; i++) if (head_bytes[i] != OkText[i]) ok_hit = 1'b0;
    err_hit = line_len >= 5;
    for (int i = 0; i < 5; i++) if (head_bytes[i] != ErrorText[i]) err_hit = 1'b0;
    if (ok_hit) begin
      due_reports.push_back('{StatusOk, '0, '0});
      go_idle();
      return;
    end
    if (err_hit) begin
      due_reports.push_back('{StatusError, '0, '0});
      go_idle();
      return;
    end
    nsonmi_hit = plus_ln && line_len == 8;
    for (int i = 0; i < 8; i++) if (head_bytes[i] != NsonmiText[i]) nsonmi_hit = 1'b0;
    if (nsonmi_hit) notif_pend = 1'b1;
    cr_seen = (b == ChCr);
  endtask

  // request stream driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    modem_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
      s_axis_tuser <= KindByte;
      send_wait <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (modem_reqs.size() != 0) begin
        nxt = modem_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.value;
        s_axis_tuser <= nxt.kind;
        send_wait <= sender_burst ? 0 : idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result stream receiver, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
      hold_left <= 0;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_burst) begin
      m_axis_tready <= 1'b1;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_wait <= idle_len();
    end
  end

  task automatic report_mismatch(string what, result_t want, result_t seen);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: %s: expected status %0d socket %0d count %0d, got status %0d socket %0d count %0d",
               $realtime, what, want.status, want.socket_number, want.byte_count,
               seen.status, seen.socket_number, seen.byte_count);
  endtask

  // monitor: predict on accepted requests, check accepted reports, watchdog
  always @(posedge clk_i) begin : monitor
    result_t seen, want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tuser, s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        seen.status = status_e'(m_axis_tuser);
        seen.socket_number = m_axis_tdata[ValueW-1:0];
        seen.byte_count = m_axis_tdata[2*ValueW-1:ValueW];
        if (due_reports.size() == 0) begin
          report_mismatch("unexpected report", '{StatusOk, '0, '0}, seen);
        end else begin
          want = due_reports.pop_front();
          if (seen.status !== want.status || seen.socket_number !== want.socket_number ||
              seen.byte_count !== want.byte_count)
            report_mismatch("report mismatch", want, seen);
        end
      end
      if (moved || !busy()) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus helpers
  task automatic add_req(logic kind, logic [7:0] b);
    modem_reqs.push_back('{kind, b});
    items_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_req(KindByte, s[i]);
  endtask

  function automatic logic [7:0] payload_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'(ChZero + $urandom_range(0, 9));
    if (r < 70) return ChComma;
    if (r < 78) return ChSpace;
    if (r < 84) return ChTab;
    if (r < 90) return "-";
    if (r < 95) return 8'("A" + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_line_end();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) add_text("\r\n");
    else if (r < 88) add_text("\n");
    else if (r < 94) begin
      add_text("\r");
      add_req(KindByte, payload_char());
    end else add_req(KindTimeout, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_line();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // receive notification with random payload
      add_text("+NSONMI:");
      if ($urandom_range(0, 9) == 0) add_text("98765");
      n = $urandom_range(0, 8);
      repeat (n) add_req(KindByte, payload_char());
      add_line_end();
    end else if (r < 47) begin
      add_text("OK");
      if ($urandom_range(0, 1) == 1) add_text("\r\n");
    end else if (r < 55) begin
      add_text("ERROR");
    end else if (r < 63) begin
      add_req(KindTimeout, 8'($urandom_range(0, 255)));
    end else if (r < 78) begin
      // ordinary reply line, sometimes long
      if ($urandom_range(0, 1) == 1) add_req(KindByte, ChPlus);
      n = $urandom_range(0, 18);
      repeat (n) add_req(KindByte, 8'($urandom_range(8'h21, 8'h7E)));
      add_line_end();
    end else if (r < 88) begin
      // near misses of the recognized heads
      case ($urandom_range(0, 6))
        0: add_text("+NSONMX:1,2\r\n");
        1: add_text("+NSONMI\r\n");
        2: add_text(" +NSONMI:3,4\r\n");
        3: add_text("O\r\n");
        4: add_text("Ok\r\n");
        5: add_text("ERRO\r\n");
        default: add_text("+NSONMI:7\r\r\n");
      endcase
    end else begin
      // raw noise
      n = $urandom_range(1, 6);
      repeat (n) add_req(KindByte, 8'($urandom_range(0, 255)));
    end
  endtask

  // sample the idle condition away from the active edge, then settle
  task automatic wait_drained();
    do @(negedge clk_i); while (busy());
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_notify_enable(bit v);
    wait_drained();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    notify_en = v;
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ok, error, timeout with all-ones byte, over-long notification
    add_text("OK");
    add_text("ERROR");
    add_req(KindTimeout, 8'hFF);
    add_text("+NSONMI:12,345\r\n");

    for (int phase = 0; phase < NumPhases; phase++) begin
      write_notify_enable(phase[0]);
      sender_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      items_queued = 0;
      if (phase == 3) begin
        // back up the result path while requests keep coming
        sender_burst = 1'b1;
        sink_burst = 1'b0;
        holdoff_req++;
        repeat (20) add_req(KindTimeout, 8'($urandom_range(0, 255)));
        repeat (10) add_text("OK\r\n");
      end
      while (items_queued < PhaseItems) add_random_line();
    end

    wait_drained();
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
